FILE: design/cile_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cile_pkg
// Shared widths and the result record of the integer constant evaluator.
// ----------------------------------------------------------------------------
package cile_pkg;

	localparam int CHAR_W  = 8;
	localparam int VALUE_W = 64;
	localparam int TYPE_W  = 3;
	localparam int STAT_W  = 2;

	typedef struct packed {
		logic [VALUE_W-1:0] const_value;
		logic [TYPE_W-1:0]  type_code;
		logic [STAT_W-1:0]  status;
		logic               overflow_warn;
		logic               forced_unsigned;
	} result_t;

endpackage
`default_nettype wire

FILE: design/cile_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cile_in_if
// Character channel: one lexeme byte per transfer, with a last marker.
// ----------------------------------------------------------------------------
interface cile_in_if;
	import cile_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              is_last;

	modport source (output valid, output char_code, output is_last, input ready);
	modport sink   (input valid, input char_code, input is_last, output ready);
endinterface
`default_nettype wire

FILE: design/cile_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cile_out_if
// Result channel: value, type, status and warning flags of one constant.
// ----------------------------------------------------------------------------
interface cile_out_if;
	import cile_pkg::*;

	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] const_value;
	logic [TYPE_W-1:0]  type_code;
	logic [STAT_W-1:0]  status;
	logic               overflow_warn;
	logic               forced_unsigned;

	modport source (output valid, output const_value, output type_code, output status,
		output overflow_warn, output forced_unsigned, input ready);
	modport sink   (input valid, input const_value, input type_code, input status,
		input overflow_warn, input forced_unsigned, output ready);
endinterface
`default_nettype wire

FILE: design/cile_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cile_scan
// Lexeme state and per-character update: prefix, digits, suffix, typing.
// ----------------------------------------------------------------------------
module cile_scan (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step_en,
	input  wire logic [cile_pkg::CHAR_W-1:0] char_code,
	input  wire logic                       is_last,
	output cile_pkg::result_t               res
);
	import cile_pkg::*;

	localparam logic [1:0] PH_PREFIX = 2'd0;
	localparam logic [1:0] PH_DIGITS = 2'd1;
	localparam logic [1:0] PH_SUFFIX = 2'd2;
	localparam logic [1:0] PH_STOP   = 2'd3;

	localparam logic [1:0] RX_DEC = 2'd0;
	localparam logic [1:0] RX_OCT = 2'd1;
	localparam logic [1:0] RX_HEX = 2'd2;

	localparam logic [1:0] RK_NONE  = 2'd0;
	localparam logic [1:0] RK_LONG  = 2'd1;
	localparam logic [1:0] RK_LLONG = 2'd2;

	localparam logic [1:0] PD_NONE = 2'd0;
	localparam logic [1:0] PD_LO   = 2'd1;
	localparam logic [1:0] PD_UP   = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_EMPTY_HEX  = 2'd1;
	localparam logic [1:0] ST_BAD_OCTAL  = 2'd2;
	localparam logic [1:0] ST_BAD_SUFFIX = 2'd3;

	localparam logic [2:0] TY_INT    = 3'd0;
	localparam logic [2:0] TY_UINT   = 3'd1;
	localparam logic [2:0] TY_LONG   = 3'd2;
	localparam logic [2:0] TY_ULONG  = 3'd3;
	localparam logic [2:0] TY_LLONG  = 3'd4;
	localparam logic [2:0] TY_ULLONG = 3'd5;

	localparam logic [CHAR_W-1:0] CH_0  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_7  = 8'h37;
	localparam logic [CHAR_W-1:0] CH_9  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UA = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UF = 8'h46;
	localparam logic [CHAR_W-1:0] CH_LA = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LF = 8'h66;
	localparam logic [CHAR_W-1:0] CH_LX = 8'h78;
	localparam logic [CHAR_W-1:0] CH_UX = 8'h58;
	localparam logic [CHAR_W-1:0] CH_LL = 8'h6c;
	localparam logic [CHAR_W-1:0] CH_UL = 8'h4c;
	localparam logic [CHAR_W-1:0] CH_LU = 8'h75;
	localparam logic [CHAR_W-1:0] CH_UU = 8'h55;

	localparam int SUM_W = VALUE_W + 4;

	typedef struct packed {
		logic [TYPE_W-1:0] code;
		logic              forced;
	} pick_t;

	// First type of the candidate list that holds the value.
	function automatic pick_t pick_type(input logic [VALUE_W-1:0] v, input logic uns,
		input logic [1:0] rank, input logic dec);
		pick_t p;
		logic  fit_int;
		logic  fit_uint;
		logic  fit_long;
		fit_int  = ~|v[VALUE_W-1:31];
		fit_uint = ~|v[VALUE_W-1:32];
		fit_long = ~v[VALUE_W-1];
		p.forced = 1'b0;
		p.code   = TY_ULLONG;
		if (uns) begin
			case (rank)
				RK_NONE: p.code = fit_uint ? TY_UINT : TY_ULONG;
				RK_LONG: p.code = TY_ULONG;
				default: p.code = TY_ULLONG;
			endcase
		end else if (dec) begin
			case (rank)
				RK_NONE: p.code = fit_int ? TY_INT : (fit_long ? TY_LONG : TY_ULLONG);
				RK_LONG: p.code = fit_long ? TY_LONG : TY_ULLONG;
				default: p.code = fit_long ? TY_LLONG : TY_ULLONG;
			endcase
			p.forced = ~fit_long;
		end else begin
			case (rank)
				RK_NONE: p.code = fit_int ? TY_INT : fit_uint ? TY_UINT :
					fit_long ? TY_LONG : TY_ULONG;
				RK_LONG: p.code = fit_long ? TY_LONG : TY_ULONG;
				default: p.code = fit_long ? TY_LLONG : TY_ULLONG;
			endcase
		end
		return p;
	endfunction

	logic [1:0]         pos_q, phase_q, radix_q, rank_q, pend_q, err_q;
	logic [VALUE_W-1:0] acc_q;
	logic               ovf_q, uns_q;

	logic [1:0]         pos_n, phase_n, radix_n, rank_n, pend_n, err_n;
	logic [VALUE_W-1:0] acc_n;
	logic               ovf_n, uns_n;

	logic [1:0]         eff_radix, rank_t, rank_f, err_f;
	logic               do_digit, do_suffix, bad, skip;
	logic               is_dec, is_hex, is_x, is_l, is_L, is_u, is_89, dig_ok;
	logic [3:0]         dig_val;
	logic [SUM_W-1:0]   acc_w, prod, sum;
	pick_t              pick;

	// character classes
	assign is_dec  = (char_code >= CH_0) && (char_code <= CH_9);
	assign is_hex  = is_dec || ((char_code >= CH_LA) && (char_code <= CH_LF)) ||
		((char_code >= CH_UA) && (char_code <= CH_UF));
	assign is_x    = (char_code == CH_LX) || (char_code == CH_UX);
	assign is_l    = (char_code == CH_LL);
	assign is_L    = (char_code == CH_UL);
	assign is_u    = (char_code == CH_LU) || (char_code == CH_UU);
	assign is_89   = is_dec && (char_code > CH_7);
	assign dig_val = is_dec ? char_code[3:0] : 4'(char_code[3:0] + 4'd9);

	// radix_q is already decimal on the first character and octal after a
	// lone leading 0, so it serves the prefix digits as well
	assign eff_radix = radix_q;

	always_comb begin
		case (eff_radix)
			RX_HEX:  dig_ok = is_hex;
			RX_OCT:  dig_ok = is_dec && !is_89;
			default: dig_ok = is_dec;
		endcase
	end

	// acc * radix + digit, four guard bits catch the carry out of 64
	assign acc_w = {4'b0, acc_q};
	always_comb begin
		case (eff_radix)
			RX_HEX:  prod = acc_w << 4;
			RX_OCT:  prod = acc_w << 3;
			default: prod = (acc_w << 3) + (acc_w << 1);
		endcase
	end
	assign sum   = prod + {{(SUM_W-4){1'b0}}, dig_val};
	assign pos_n = (pos_q == 2'd3) ? pos_q : 2'(pos_q + 2'd1);

	always_comb begin
		phase_n   = phase_q;
		radix_n   = radix_q;
		acc_n     = acc_q;
		ovf_n     = ovf_q;
		uns_n     = uns_q;
		rank_n    = rank_q;
		pend_n    = pend_q;
		err_n     = err_q;
		do_digit  = 1'b0;
		do_suffix = 1'b0;
		bad       = 1'b0;
		skip      = 1'b0;
		rank_t    = rank_q;

		unique case (phase_q)
			PH_PREFIX: begin
				if (pos_q == 2'd0) begin
					if (char_code == CH_0) begin
						radix_n = RX_OCT;
					end else begin
						radix_n   = RX_DEC;
						phase_n   = PH_DIGITS;
						do_digit  = 1'b1;
					end
				end else if (is_x) begin
					radix_n = RX_HEX;
					phase_n = PH_DIGITS;
				end else begin
					radix_n   = RX_OCT;
					phase_n   = PH_DIGITS;
					do_digit  = 1'b1;
				end
			end
			PH_DIGITS: do_digit = 1'b1;
			PH_SUFFIX: do_suffix = 1'b1;
			default: ;
		endcase

		if (do_digit) begin
			if (dig_ok) begin
				acc_n = sum[VALUE_W-1:0];
				if (|sum[SUM_W-1:VALUE_W]) ovf_n = 1'b1;
			end else if (eff_radix == RX_HEX && pos_q == 2'd2) begin
				err_n   = ST_EMPTY_HEX;
				phase_n = PH_STOP;
			end else begin
				phase_n   = PH_SUFFIX;
				do_suffix = 1'b1;
			end
		end

		if (do_suffix) begin
			// resolve a held l/L first: a matching letter makes it long long
			if (pend_q != PD_NONE) begin
				pend_n = PD_NONE;
				if ((pend_q == PD_LO && is_l) || (pend_q == PD_UP && is_L)) begin
					rank_n = RK_LLONG;
					skip   = 1'b1;
				end else begin
					rank_t = RK_LONG;
					rank_n = RK_LONG;
				end
			end
			if (!skip) begin
				if (is_u) begin
					if (uns_q) bad = 1'b1;
					else uns_n = 1'b1;
				end else if (is_l || is_L) begin
					if (rank_t != RK_NONE) bad = 1'b1;
					else pend_n = is_l ? PD_LO : PD_UP;
				end else begin
					bad = 1'b1;
				end
				if (bad) begin
					err_n   = (eff_radix == RX_OCT && is_89) ? ST_BAD_OCTAL : ST_BAD_SUFFIX;
					phase_n = PH_STOP;
				end
			end
		end

		// end of lexeme: a lone pending l counts as long, bare 0x is empty hex
		rank_f = (pend_n != PD_NONE) ? RK_LONG : rank_n;
		err_f  = (err_n == ST_OK && radix_n == RX_HEX && pos_n == 2'd2) ? ST_EMPTY_HEX
			: err_n;
	end

	assign pick = pick_type(acc_n, uns_n, rank_f, radix_n == RX_DEC);

	always_comb begin
		if (err_f == ST_EMPTY_HEX) begin
			res.const_value     = '0;
			res.type_code       = TY_INT;
			res.status          = ST_EMPTY_HEX;
			res.overflow_warn   = 1'b0;
			res.forced_unsigned = 1'b0;
		end else begin
			res.const_value     = acc_n;
			res.type_code       = pick.code;
			res.status          = err_f;
			res.overflow_warn   = ovf_n;
			res.forced_unsigned = pick.forced;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 2'd0;
			phase_q <= PH_PREFIX;
			radix_q <= RX_DEC;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			uns_q   <= 1'b0;
			rank_q  <= RK_NONE;
			pend_q  <= PD_NONE;
			err_q   <= ST_OK;
		end else if (step_en) begin
			if (is_last) begin
				pos_q   <= 2'd0;
				phase_q <= PH_PREFIX;
				radix_q <= RX_DEC;
				acc_q   <= '0;
				ovf_q   <= 1'b0;
				uns_q   <= 1'b0;
				rank_q  <= RK_NONE;
				pend_q  <= PD_NONE;
				err_q   <= ST_OK;
			end else begin
				pos_q   <= pos_n;
				phase_q <= phase_n;
				radix_q <= radix_n;
				acc_q   <= acc_n;
				ovf_q   <= ovf_n;
				uns_q   <= uns_n;
				rank_q  <= rank_n;
				pend_q  <= pend_n;
				err_q   <= err_n;
			end
		end
	end

`ifndef SYNTHESIS
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && is_last |=> phase_q == PH_PREFIX && pos_q == 2'd0 && acc_q == '0)
		else $error("state not cleared after end of lexeme");
	a_pend_rank: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != PD_NONE |-> rank_q == RK_NONE && phase_q == PH_SUFFIX)
		else $error("pending l alongside a long rank");
	a_stop_err: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_STOP) == (err_q != ST_OK))
		else $error("stop phase and error code disagree");
	a_hex_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		radix_q == RX_HEX |-> phase_q != PH_PREFIX && pos_q >= 2'd2)
		else $error("hex radix before the prefix is complete");
`endif

endmodule
`default_nettype wire

FILE: design/c_integer_literal_eval_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c_integer_literal_eval_top
// C integer constant evaluator: radix, value, suffix and LP64 type.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                          | transfer
//  ---------+-----+--------------------------------------------------+----------
//  lexeme   | in  | char_code[7:0], is_last                          | valid&ready
//  result   | out | const_value[63:0], type_code[2:0], status[1:0],  | valid&ready
//           |     | overflow_warn, forced_unsigned                   |
//
//  One character per cycle, sustained while no result is stalled. A
//  character is held in the input register, then updates the lexeme state;
//  on the last character the result register is loaded in that same step.
//  The per-character path is the radix multiply-add (shifts and up to two
//  adders) followed by the type pick on the updated value.
//  arst_n clears the lexeme state and both valid flags at once.
//  A stalled result blocks only a last character; while it is held in the
//  input register, no further character is taken.
// ----------------------------------------------------------------------------
module c_integer_literal_eval_top (
	input wire logic clk,
	input wire logic arst_n,
	cile_in_if.sink   lexeme,
	cile_out_if.source result
);
	import cile_pkg::*;

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;
	logic              adv;
	logic              take;
	logic              out_valid_q;
	result_t           res_q;
	result_t           res_d;

	// advance the held character unless it closes a lexeme and the result is stuck
	assign adv          = valid_s1 && (!last_s1 || !out_valid_q || result.ready);
	assign lexeme.ready = !valid_s1 || adv;
	assign take         = lexeme.valid && lexeme.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload only: hold while no transfer
	always_ff @(posedge clk) begin
		if (take) begin
			char_s1 <= lexeme.char_code;
			last_s1 <= lexeme.is_last;
		end
	end

	cile_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (adv),
		.char_code (char_s1),
		.is_last   (last_s1),
		.res       (res_d)
	);

	// result register: load on the last character, drop after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			res_q <= res_d;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.const_value     = res_q.const_value;
	assign result.type_code       = res_q.type_code;
	assign result.status          = res_q.status;
	assign result.overflow_warn   = res_q.overflow_warn;
	assign result.forced_unsigned = res_q.forced_unsigned;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |=> out_valid_q && $stable(res_q))
		else $error("pending result overwritten");
	a_held_char: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(char_s1) && $stable(last_s1))
		else $error("stalled character lost");
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |-> last_s1 && out_valid_q && !result.ready)
		else $error("character stalled without a blocked result");
`endif

endmodule
`default_nettype wire
